>>> rtl/core/mqbrb_pkg.sv
// package for the multi-queue byte ring buffer
// holds item structs, action and status codes and the percent scale
// no dependencies
package mqbrb_pkg;

    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_POP   = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam int PCT_SCALE = 100;
    localparam int PCT_W     = 7;
    localparam int COUNT_W   = 13;

    typedef struct packed {
        logic [1:0] action;
        logic [1:0] queue_sel;
        logic [7:0] push_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [7:0]         pop_byte;
        logic [COUNT_W-1:0] fill_count;
        logic [PCT_W-1:0]   fill_percent;
    } t_out_item;

endpackage

>>> rtl/core/mqbrb_pct_div.sv
// fill percentage unit: floor(count*100/capacity) by reciprocal multiplication
// result registered in the cycle after start; uses mqbrb_pkg for the scale and quotient width
module mqbrb_pct_div #(
    parameter int CAPACITY = 4096,
    parameter int CNT_W    = 13
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [CNT_W-1:0]              i_cnt,
    output logic                          o_done,
    output logic [mqbrb_pkg::PCT_W-1:0]   o_quo
);

    localparam int     QW    = mqbrb_pkg::PCT_W;
    // count times the scale stays below 2**NW
    localparam int     NW    = $clog2(CAPACITY * mqbrb_pkg::PCT_SCALE + 1);
    localparam int     SH    = NW + $clog2(CAPACITY);
    // reciprocal rounded up is exact for every numerator below 2**NW
    localparam longint RECIP = ((longint'(1) << SH) + longint'(CAPACITY) - longint'(1))
                               / longint'(CAPACITY);
    localparam longint KVAL  = RECIP * longint'(mqbrb_pkg::PCT_SCALE);
    localparam int     KW    = $clog2(KVAL + 1);
    localparam int     PRW   = CNT_W + KW;
    localparam logic [KW-1:0] K = KW'(KVAL);

    logic [PRW-1:0] prod;
    logic           r_done;
    logic [QW-1:0]  r_quo;

    // constant multiplier, scale and reciprocal folded together
    assign prod = PRW'(i_cnt) * PRW'(K);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= QW'(prod >> SH);
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

>>> rtl/core/multi_queue_byte_ring_buffer_unit.sv
// top level of the multi-queue byte ring buffer
// uses mqbrb_pkg and mqbrb_pct_div; byte store is an internal synchronous memory
//
// QUEUES circular byte FIFOs of CAPACITY bytes each share one byte memory of
// QUEUES*CAPACITY entries; fill counts and pointers sit in per-queue registers
// cleared by reset, so no clearing pass is needed. Each item pushes, pops or
// queries one queue and yields exactly one result item. On the way to the result
// register, the push write or pop read happens at the accept edge, the fill
// percentage comes from a constant reciprocal multiplication registered on the
// next cycle, and the controller then steps through its divide and output
// states, loading the result once the output register is free. The input stalls
// until the result is loaded, so no new item is taken while one is in flight;
// a result waiting in the output register lets the next item in, which then
// waits at the load step.
module multi_queue_byte_ring_buffer_unit #(
    parameter int QUEUES   = 4,
    parameter int CAPACITY = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  mqbrb_pkg::t_in_item   i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output mqbrb_pkg::t_out_item  o_out_item
);

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int PW  = $clog2(CAPACITY);
    localparam int QIW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int AW  = $clog2(QUEUES * CAPACITY);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [7:0]    mem [QUEUES*CAPACITY];
    logic [7:0]    r_rd_data;

    logic [CW-1:0] r_cnt [QUEUES];
    logic [PW-1:0] r_wp  [QUEUES];
    logic [PW-1:0] r_rp  [QUEUES];

    logic [1:0]    r_state;
    logic          r_start;
    logic [1:0]    r_status;
    logic          r_pop_ok;
    logic          r_in_range;
    logic [CW-1:0] r_new_cnt;

    logic                   r_out_valid;
    mqbrb_pkg::t_out_item   r_out;

    logic                   accept;
    logic                   in_range;
    logic [QIW-1:0]         qi;
    logic [CW-1:0]          cur_cnt;
    logic                   do_push;
    logic                   do_pop;
    logic [1:0]             n_status;
    logic [CW-1:0]          n_cnt;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          rd_addr;
    logic                   div_done;
    logic [mqbrb_pkg::PCT_W-1:0] div_quo;
    logic                   out_free;

    assign accept   = i_in_valid && !o_in_stall;
    assign in_range = 32'(i_in_item.queue_sel) < QUEUES;
    assign qi       = QIW'(i_in_item.queue_sel);
    assign cur_cnt  = r_cnt[qi];
    assign wr_addr  = AW'(32'(qi) * CAPACITY + 32'(r_wp[qi]));
    assign rd_addr  = AW'(32'(qi) * CAPACITY + 32'(r_rp[qi]));
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        do_push  = 1'b0;
        do_pop   = 1'b0;
        n_status = mqbrb_pkg::ST_DONE;
        n_cnt    = cur_cnt;
        if (in_range) begin
            case (i_in_item.action)
                mqbrb_pkg::ACT_PUSH: begin
                    if (cur_cnt == CW'(CAPACITY)) begin
                        n_status = mqbrb_pkg::ST_FULL;
                    end else begin
                        do_push = 1'b1;
                        n_cnt   = cur_cnt + CW'(1);
                    end
                end
                mqbrb_pkg::ACT_POP: begin
                    if (cur_cnt == '0) begin
                        n_status = mqbrb_pkg::ST_EMPTY;
                    end else begin
                        do_pop = 1'b1;
                        n_cnt  = cur_cnt - CW'(1);
                    end
                end
                default: begin
                    // query and the reserved code leave the queue untouched
                end
            endcase
        end
    end

    // byte store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (accept && do_push) begin
            mem[wr_addr] <= i_in_item.push_byte;
        end
        if (accept && do_pop) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QUEUES; i++) begin
                r_cnt[i] <= '0;
                r_wp[i]  <= '0;
                r_rp[i]  <= '0;
            end
        end else if (accept && in_range) begin
            r_cnt[qi] <= n_cnt;
            if (do_push) begin
                r_wp[qi] <= (r_wp[qi] == PW'(CAPACITY - 1)) ? '0 : r_wp[qi] + PW'(1);
            end
            if (do_pop) begin
                r_rp[qi] <= (r_rp[qi] == PW'(CAPACITY - 1)) ? '0 : r_rp[qi] + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status   <= n_status;
            r_pop_ok   <= do_pop;
            r_in_range <= in_range;
            r_new_cnt  <= in_range ? n_cnt : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_DIV;
                        r_start <= 1'b1;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out.status       <= r_status;
            r_out.pop_byte     <= r_pop_ok ? r_rd_data : 8'd0;
            r_out.fill_count   <= r_in_range ? mqbrb_pkg::COUNT_W'(r_new_cnt) : '0;
            r_out.fill_percent <= div_quo;
        end
    end

    mqbrb_pct_div #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CW)
    ) u_pct_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_cnt   (r_new_cnt),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // percentage never exceeds the scale
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (32'(div_quo) <= mqbrb_pkg::PCT_SCALE))
        else $error("fill percent above scale");

    // a new result only comes from the output state
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("result loaded outside output state");

    // a refused push reports a full queue
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == mqbrb_pkg::ST_FULL)
            |-> (r_out.fill_count == mqbrb_pkg::COUNT_W'(CAPACITY)))
        else $error("full status with count below capacity");

    // divider is only started from the idle handoff
    a_start_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> (r_state == S_DIV && $past(r_state) == S_IDLE))
        else $error("divider started out of sequence");

endmodule

>>> test/tb_top.sv
// testbench for the multi-queue byte ring buffer: directed, burst, back-pressure and random items
// a behavioral predictor checks every result item; depends on mqbrb_pkg and the rtl top level
// self-contained, no files or arguments
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUES         = 4;
    localparam int CAPACITY       = 4096;
    localparam int QI_W           = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int PTR_W          = $clog2(CAPACITY);
    localparam int RESULT_LATENCY = 12;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int SHOW_LIMIT     = 10;
    localparam int PHASE_ITEMS    = 250;
    localparam int BURST_ITEMS    = 80;
    localparam logic [1:0] ACT_RSVD = 2'd3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    mqbrb_pkg::t_in_item  i_in_item = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    mqbrb_pkg::t_out_item o_out_item;

    // predictor state
    logic [7:0]       ring_mem [QUEUES][CAPACITY];
    int unsigned      fill_level [QUEUES];
    logic [PTR_W-1:0] wr_ptr [QUEUES];
    logic [PTR_W-1:0] rd_ptr [QUEUES];

    mqbrb_pkg::t_out_item expected_results[$];
    int        mismatch_count = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        long_hold_len = 0;
    int        hold_count = 0;

    multi_queue_byte_ring_buffer_unit #(
        .QUEUES   (QUEUES),
        .CAPACITY (CAPACITY)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic mqbrb_pkg::t_out_item predict_queue_op(input mqbrb_pkg::t_in_item it);
        mqbrb_pkg::t_out_item res;
        logic [QI_W-1:0]      qi;
        res = '0;
        if (32'(it.queue_sel) >= QUEUES) begin
            return res;
        end
        qi = QI_W'(it.queue_sel);
        res.status = mqbrb_pkg::ST_DONE;
        case (it.action)
            mqbrb_pkg::ACT_PUSH: begin
                if (fill_level[qi] >= CAPACITY) begin
                    res.status = mqbrb_pkg::ST_FULL;
                end else begin
                    ring_mem[qi][wr_ptr[qi]] = it.push_byte;
                    wr_ptr[qi] = (wr_ptr[qi] == PTR_W'(CAPACITY - 1)) ? '0
                                                                      : wr_ptr[qi] + PTR_W'(1);
                    fill_level[qi]++;
                end
            end
            mqbrb_pkg::ACT_POP: begin
                if (fill_level[qi] == 0) begin
                    res.status = mqbrb_pkg::ST_EMPTY;
                end else begin
                    res.pop_byte = ring_mem[qi][rd_ptr[qi]];
                    rd_ptr[qi] = (rd_ptr[qi] == PTR_W'(CAPACITY - 1)) ? '0
                                                                      : rd_ptr[qi] + PTR_W'(1);
                    fill_level[qi]--;
                end
            end
            default: ;  // query and the reserved code only report
        endcase
        res.fill_count   = mqbrb_pkg::COUNT_W'(fill_level[qi]);
        res.fill_percent = mqbrb_pkg::PCT_W'((fill_level[qi] * mqbrb_pkg::PCT_SCALE) / CAPACITY);
        return res;
    endfunction

    // offers one item; valid stays high after acceptance so back-to-back items need no gap
    task automatic send_item(input logic [1:0] act, input logic [1:0] q, input logic [7:0] b);
        mqbrb_pkg::t_in_item it;
        it.action    = act;
        it.queue_sel = q;
        it.push_byte = b;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        expected_results.push_back(predict_queue_op(it));
    endtask

    task automatic wait_drain();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_results.size() != 0) begin
            mismatch_count++;
            $display("no result for %0d accepted items", expected_results.size());
            expected_results.delete();
        end
        repeat (RESULT_LATENCY) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (hold_count < long_hold_len) begin
            i_out_stall <= 1'b1;
            hold_count  <= hold_count + 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        mqbrb_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= SHOW_LIMIT) begin
                    $display("unexpected result: status=%0d pop_byte=%02h count=%0d pct=%0d",
                             o_out_item.status, o_out_item.pop_byte,
                             o_out_item.fill_count, o_out_item.fill_percent);
                end
            end else begin
                want = expected_results.pop_front();
                if (o_out_item.status !== want.status
                        || o_out_item.pop_byte !== want.pop_byte
                        || o_out_item.fill_count !== want.fill_count
                        || o_out_item.fill_percent !== want.fill_percent) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_LIMIT) begin
                        $display("mismatch at %0t: expected status=%0d pop_byte=%02h count=%0d pct=%0d",
                                 $realtime, want.status, want.pop_byte,
                                 want.fill_count, want.fill_percent);
                        $display("                  got status=%0d pop_byte=%02h count=%0d pct=%0d",
                                 o_out_item.status, o_out_item.pop_byte,
                                 o_out_item.fill_count, o_out_item.fill_percent);
                    end
                end
            end
        end
    end

    task automatic test_directed_basics();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_item(mqbrb_pkg::ACT_QUERY, 2'd0, 8'h00);
        send_item(ACT_RSVD, 2'd3, 8'hFF);
        send_item(mqbrb_pkg::ACT_POP, 2'd0, 8'hFF);      // empty queue refuses a pop
        send_item(mqbrb_pkg::ACT_PUSH, 2'd0, 8'h00);
        send_item(mqbrb_pkg::ACT_PUSH, 2'd0, 8'hFF);
        send_item(mqbrb_pkg::ACT_PUSH, 2'd1, 8'hA5);
        send_item(mqbrb_pkg::ACT_PUSH, 2'd2, 8'h5A);
        send_item(mqbrb_pkg::ACT_PUSH, 2'd3, 8'h81);
        send_item(ACT_RSVD, 2'd0, 8'h7E);
        send_item(mqbrb_pkg::ACT_QUERY, 2'd1, 8'hC3);
        send_item(mqbrb_pkg::ACT_POP, 2'd0, 8'h3C);
        send_item(mqbrb_pkg::ACT_POP, 2'd0, 8'h00);
        send_item(mqbrb_pkg::ACT_POP, 2'd0, 8'h00);
        send_item(mqbrb_pkg::ACT_POP, 2'd1, 8'h00);
        send_item(mqbrb_pkg::ACT_POP, 2'd2, 8'hFF);
        send_item(mqbrb_pkg::ACT_POP, 2'd3, 8'h00);
        send_item(mqbrb_pkg::ACT_POP, 2'd3, 8'h00);
        send_item(mqbrb_pkg::ACT_QUERY, 2'd3, 8'h00);
        wait_drain();
    endtask

    // a burst of pushes into one queue, then drain it one past empty
    task automatic test_burst_drain();
        send_idle_pct  = 19;
        recv_stall_pct = 19;
        repeat (BURST_ITEMS) send_item(mqbrb_pkg::ACT_PUSH, 2'd1, 8'($urandom_range(255)));
        send_item(mqbrb_pkg::ACT_QUERY, 2'd1, 8'h00);
        repeat (BURST_ITEMS + 1) send_item(mqbrb_pkg::ACT_POP, 2'd1, 8'h00);
        wait_drain();
    endtask

    // receiver holds off while items keep coming, so the input has to stall
    task automatic test_back_pressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        long_hold_len  = 300;
        for (int k = 0; k < 24; k++) begin
            send_item((k % 3 == 2) ? mqbrb_pkg::ACT_POP : mqbrb_pkg::ACT_PUSH,
                      2'(k % 2 ? 2 : 0), 8'($urandom_range(255)));
        end
        wait_drain();
    endtask

    task automatic test_random_mix(input int idle_pct, input int stall_pct, input int n_items);
        int         focus_q;
        int         push_pct;
        int         r;
        logic [1:0] act;
        logic [1:0] q;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        focus_q  = 0;
        push_pct = 50;
        for (int k = 0; k < n_items; k++) begin
            // short runs that mostly fill or mostly drain one queue
            if (k % 40 == 0) begin
                focus_q  = $urandom_range(QUEUES - 1);
                push_pct = $urandom_range(1) ? 70 : 25;
            end
            r = $urandom_range(99);
            if (r < push_pct) begin
                act = mqbrb_pkg::ACT_PUSH;
            end else if (r < 88) begin
                act = mqbrb_pkg::ACT_POP;
            end else if (r < 94) begin
                act = mqbrb_pkg::ACT_QUERY;
            end else begin
                act = ACT_RSVD;
            end
            q = $urandom_range(1) ? 2'(focus_q) : 2'($urandom_range(QUEUES - 1));
            send_item(act, q, 8'($urandom_range(255)));
        end
        wait_drain();
    endtask

    initial begin
        fill_level = '{default: 0};
        wr_ptr     = '{default: '0};
        rd_ptr     = '{default: '0};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_basics();
        test_burst_drain();
        test_back_pressure();
        test_random_mix(0, 0, PHASE_ITEMS);
        test_random_mix(67, 0, PHASE_ITEMS);
        test_random_mix(0, 67, PHASE_ITEMS);
        test_random_mix(19, 19, PHASE_ITEMS);

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/mqbrb_pkg.sv
rtl/core/mqbrb_pct_div.sv
rtl/core/multi_queue_byte_ring_buffer_unit.sv
test/tb_top.sv
